// ===== hdl/interval_union_merge_defines.svh =====
// Assertion macros shared by the checker of the interval union merger.
// Holds only macro definitions; no dependencies.
`ifndef INTERVAL_UNION_MERGE_DEFINES_SVH
`define INTERVAL_UNION_MERGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IUM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IUM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ium_pkg.sv =====
// Shared types of the interval union merger: table cell and result load.
// No dependencies.
package ium_pkg;

	localparam int DW = 32;

	// One table cell: lower bound in the upper half, upper bound in the lower half.
	typedef struct packed {
		logic signed [DW-1:0] lo;
		logic signed [DW-1:0] hi;
	} cell_t;

	// Load request from the sequencer to the output register.
	typedef struct packed {
		logic                 load;
		logic signed [DW-1:0] start_v;
		logic signed [DW-1:0] finish_v;
		logic                 last_res;
		logic                 empty;
		logic                 ovf;
	} out_ld_t;

endpackage

// ===== hdl/interval_union_merge.sv =====
// Interval union merger top level: sequencer, interval table memory, output register.
// Depends on ium_pkg, ium_seq and ium_store.
// An item that is stored walks down the table and moves up the cells with a larger start
// (0 to MAX_INTERVALS-1 of them); the first item of a set and a dropped item need no walk.
// A last item starts the merge scan; the results then follow one per cycle while the
// output is not stalled. Reset clears control state and counts; the table stays undefined.
module interval_union_merge #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ium_pkg::DW-1:0] start_req,
	input  logic signed [ium_pkg::DW-1:0] finish,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ium_pkg::DW-1:0] merged_start,
	output logic signed [ium_pkg::DW-1:0] merged_finish,
	output logic                          final_result,
	output logic                          empty_set,
	output logic                          overflowed
);

	localparam int AW = $clog2(MAX_INTERVALS);

	// The table keeps the stored intervals sorted by ascending start. An input
	// item is inserted by walking down from the top cell: each cycle one cell
	// is read and, when its start is larger, written one place higher, so the
	// single read port of the table sets the insertion time.
	//
	// The last item of a set starts the merge. The table is read in ascending
	// order; each finished group of overlapping or touching intervals is
	// written back in place at the group count, which never passes the read
	// pointer. The groups are then read back from the highest down, giving the
	// results in order of descending start.

	ium_pkg::out_ld_t ld;
	logic             out_free;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	ium_pkg::cell_t   mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	ium_pkg::cell_t   mem_rdata;
	logic             out_valid_q;

	// A new result may enter when the register is empty or is being taken.
	assign out_free = !out_valid_q || !out_stall;

	ium_seq #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_req (start_req),
		.finish    (finish),
		.last_item (last_item),
		.out_free  (out_free),
		.ld        (ld),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ium_store #(
		.DEPTH(MAX_INTERVALS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: it decouples the result side, so the block can take the
	// next input item while the final result of a set still waits downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			merged_start  <= ld.start_v;
			merged_finish <= ld.finish_v;
			final_result  <= ld.last_res;
			empty_set     <= ld.empty;
			overflowed    <= ld.ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/ium_store.sv =====
// Interval table memory: one write port, one read port, registered read data.
// Depends on ium_pkg for the cell type.
module ium_store #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  ium_pkg::cell_t    wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output ium_pkg::cell_t    rdata
);

	ium_pkg::cell_t mem [DEPTH];

	// Read data only moves when a read is issued, so it holds while the consumer waits.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ium_seq.sv =====
// Sequencer of the interval union merger: sorted insertion, merge scan and readout.
// Depends on ium_pkg; drives the ports of ium_store.
module ium_seq #(
	parameter int MAX_INTERVALS = 16,
	localparam int AW = $clog2(MAX_INTERVALS),
	localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ium_pkg::DW-1:0] start_req,
	input  logic signed [ium_pkg::DW-1:0] finish,
	input  logic                          last_item,
	input  logic                          out_free,
	output ium_pkg::out_ld_t              ld,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output ium_pkg::cell_t                mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  ium_pkg::cell_t                mem_rdata
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_INS    = 9'b000000010,
		ST_MRD0   = 9'b000000100,
		ST_MFIRST = 9'b000001000,
		ST_MSCAN  = 9'b000010000,
		ST_MEND   = 9'b000100000,
		ST_ERD    = 9'b001000000,
		ST_EMIT   = 9'b010000000,
		ST_EMPTY  = 9'b100000000
	} state_t;

	localparam logic [CW-1:0] FULL = CW'(MAX_INTERVALS);

	state_t                       state_q, state_d;
	logic [CW-1:0]                cnt_q, cnt_d;
	logic                         ovf_q, ovf_d;
	ium_pkg::cell_t               cell_q, cell_d;
	logic                         last_q, last_d;
	logic [AW-1:0]                pos_q, pos_d;
	logic [AW-1:0]                di_q, di_d;
	logic [AW-1:0]                m_q, m_d;
	logic signed [ium_pkg::DW-1:0] cs_q, cs_d;
	logic signed [ium_pkg::DW-1:0] cf_q, cf_d;

	logic                         acc;
	logic                         ok;
	logic                         full;
	logic                         ins;
	logic [AW-1:0]                cnt_m1;
	ium_pkg::cell_t               rd;
	logic signed [ium_pkg::DW:0]  a_ext;
	logic signed [ium_pkg::DW:0]  cf_inc;
	logic                         join_grp;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign ok       = (finish >= start_req);
	assign full     = (cnt_q == FULL);
	assign ins      = acc && ok && !full;
	assign cnt_m1   = AW'(cnt_q - CW'(1));
	assign rd       = mem_rdata;

	// Adjacency test at one bit more than the bounds, so the top value does not wrap.
	assign a_ext    = {rd.lo[ium_pkg::DW-1], rd.lo};
	assign cf_inc   = {cf_q[ium_pkg::DW-1], cf_q} + (ium_pkg::DW+1)'(1);
	assign join_grp = (a_ext <= cf_inc);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ovf_d     = ovf_q;
		cell_d    = cell_q;
		last_d    = last_q;
		pos_d     = pos_q;
		di_d      = di_q;
		m_d       = m_q;
		cs_d      = cs_q;
		cf_d      = cf_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cell_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		ld        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cell_d = '{lo: start_req, hi: finish};
					last_d = last_item;
					if (ok && full) begin
						ovf_d = 1'b1;
					end
					if (ins && cnt_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = '{lo: start_req, hi: finish};
						cnt_d     = CW'(1);
						if (last_item) begin
							state_d = ST_MRD0;
						end
					end else if (ins) begin
						// Walk down from the top cell, moving larger starts up one place.
						mem_re    = 1'b1;
						mem_raddr = cnt_m1;
						pos_d     = AW'(cnt_q);
						state_d   = ST_INS;
					end else if (last_item) begin
						state_d = (cnt_q == '0) ? ST_EMPTY : ST_MRD0;
					end
				end
			end
			ST_INS: begin
				if (pos_q != '0 && rd.lo > cell_q.lo) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = rd;
					pos_d     = pos_q - AW'(1);
					mem_re    = 1'b1;
					mem_raddr = pos_q - AW'(2);
				end else begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = cell_q;
					cnt_d     = cnt_q + CW'(1);
					state_d   = last_q ? ST_MRD0 : ST_IDLE;
				end
			end
			ST_MRD0: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
				state_d   = ST_MFIRST;
			end
			ST_MFIRST: begin
				cs_d = rd.lo;
				cf_d = rd.hi;
				m_d  = '0;
				if (cnt_q == CW'(1)) begin
					state_d = ST_MEND;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(1);
					di_d      = AW'(1);
					state_d   = ST_MSCAN;
				end
			end
			ST_MSCAN: begin
				// Closed groups are written back in place below the read pointer.
				if (join_grp) begin
					if (rd.hi > cf_q) begin
						cf_d = rd.hi;
					end
				end else begin
					mem_we    = 1'b1;
					mem_waddr = m_q;
					mem_wdata = '{lo: cs_q, hi: cf_q};
					m_d       = m_q + AW'(1);
					cs_d      = rd.lo;
					cf_d      = rd.hi;
				end
				if (di_q == cnt_m1) begin
					state_d = ST_MEND;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = di_q + AW'(1);
					di_d      = di_q + AW'(1);
				end
			end
			ST_MEND: begin
				mem_we    = 1'b1;
				mem_waddr = m_q;
				mem_wdata = '{lo: cs_q, hi: cf_q};
				state_d   = ST_ERD;
			end
			ST_ERD: begin
				mem_re    = 1'b1;
				mem_raddr = m_q;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					ld.load     = 1'b1;
					ld.start_v  = rd.lo;
					ld.finish_v = rd.hi;
					ld.last_res = (m_q == '0);
					ld.empty    = 1'b0;
					ld.ovf      = ovf_q;
					if (m_q == '0) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = m_q - AW'(1);
						m_d       = m_q - AW'(1);
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					ld.load     = 1'b1;
					ld.start_v  = '0;
					ld.finish_v = '0;
					ld.last_res = 1'b1;
					ld.empty    = 1'b1;
					ld.ovf      = ovf_q;
					cnt_d       = '0;
					ovf_d       = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
		last_q <= last_d;
		pos_q  <= pos_d;
		di_q   <= di_d;
		m_q    <= m_d;
		cs_q   <= cs_d;
		cf_q   <= cf_d;
	end

endmodule

// ===== hdl/ium_chk.sv =====
// Port-level checker of the interval union merger, bound to the top level.
// Depends on interval_union_merge_defines.svh for the assertion macros.
`include "interval_union_merge_defines.svh"

module ium_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_item,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [ium_pkg::DW-1:0] merged_start,
	input logic signed [ium_pkg::DW-1:0] merged_finish,
	input logic                          final_result,
	input logic                          empty_set
);

	// A stalled result keeps its contents.
	`IUM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(merged_start) && $stable(merged_finish) && $stable(final_result) && $stable(empty_set), "stalled result changed")

	// The result of an empty set is the only result of its run.
	`IUM_ASSERT_SAME(a_empty_last, clk, arst_n, out_valid && empty_set, final_result, "empty result not flagged last")

	// The result of an empty set carries zero bounds.
	`IUM_ASSERT_SAME(a_empty_zero, clk, arst_n, out_valid && empty_set, merged_start == '0 && merged_finish == '0, "empty result bounds not zero")

	// A merged interval is never inverted.
	`IUM_ASSERT_SAME(a_order, clk, arst_n, out_valid && !empty_set, merged_finish >= merged_start, "merged interval inverted")

	// A last item always starts work that blocks the input right after it is taken.
	`IUM_ASSERT_NEXT(a_last_busy, clk, arst_n, in_valid && !in_stall && last_item, in_stall, "input open right after a last item")

endmodule

bind interval_union_merge ium_chk u_chk (.*);
